FILE: rtl/csvt_pkg.sv
// csvt_pkg: shared types and constants of the csv byte tokenizer
// used by every module of the block; depends on nothing

package csvt_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

  // one decoded input item: an optional released carriage return, then an optional main result
  typedef struct packed {
    logic       has_cr;
    logic       has_main;
    kind_t      kind;
    logic [7:0] content;
  } cmd_t;

endpackage

FILE: rtl/csvt_if.sv
// csvt_if: valid/ready channel interfaces of the csv byte tokenizer
// depends on csvt_pkg for the result kind type

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface csvt_out_if;
  logic               valid;
  logic               ready;
  csvt_pkg::kind_t    kind;
  logic [7:0]         content;
  logic               last;

  modport source (output valid, output kind, output content, output last, input ready);
  modport sink   (input valid, input kind, input content, input last, output ready);
endinterface

FILE: rtl/csvt_front.sv
// csvt_front: accepts bytes, runs the quote / carriage return state and decodes results
// depends on csvt_pkg and csvt_if; feeds csvt_queue

module csvt_front (
  input  logic            clk,
  input  logic            rst_n,
  csvt_in_if.sink         in_ch,
  input  logic            q_ready,
  output logic            push,
  output csvt_pkg::cmd_t  cmd
);

  logic in_quotes_r, in_quotes_nxt;
  logic quote_pending_r, quote_pending_nxt;
  logic cr_held_r, cr_held_nxt;
  logic field_nonempty_r, field_nonempty_nxt;
  logic row_nonempty_r, row_nonempty_nxt;

  logic       accept;
  logic       do_plain;
  logic       do_add;
  logic [7:0] add_b;
  logic [7:0] b;

  assign b           = in_ch.data_byte;
  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;
  assign push        = accept && (cmd.has_cr || cmd.has_main);

  always_comb begin
    in_quotes_nxt      = in_quotes_r;
    quote_pending_nxt  = quote_pending_r;
    cr_held_nxt        = cr_held_r;
    field_nonempty_nxt = field_nonempty_r;
    row_nonempty_nxt   = row_nonempty_r;
    cmd                = '0;
    do_plain           = 1'b0;
    do_add             = 1'b0;
    add_b              = b;

    if (in_ch.mode) begin
      // end of input: close the row if anything was seen, then start over
      if (field_nonempty_r || row_nonempty_r) begin
        cmd.has_main = 1'b1;
        cmd.kind     = csvt_pkg::KIND_ROW;
      end
      in_quotes_nxt      = 1'b0;
      quote_pending_nxt  = 1'b0;
      cr_held_nxt        = 1'b0;
      field_nonempty_nxt = 1'b0;
      row_nonempty_nxt   = 1'b0;
    end else begin
      if (in_quotes_r && quote_pending_r) begin
        quote_pending_nxt = 1'b0;
        if (b == csvt_pkg::CH_QUOTE) begin
          do_add = 1'b1;
          add_b  = csvt_pkg::CH_QUOTE;
        end else begin
          in_quotes_nxt = 1'b0;
          do_plain      = 1'b1;
        end
      end else if (in_quotes_r) begin
        if (b == csvt_pkg::CH_QUOTE) begin
          quote_pending_nxt = 1'b1;
        end else begin
          do_add = 1'b1;
        end
      end else begin
        quote_pending_nxt = 1'b0;
        do_plain          = 1'b1;
      end

      if (do_plain) begin
        if (b == csvt_pkg::CH_QUOTE) begin
          in_quotes_nxt = 1'b1;
        end else if (b == csvt_pkg::CH_COMMA) begin
          cmd.has_cr         = cr_held_r;
          cr_held_nxt        = 1'b0;
          cmd.has_main       = 1'b1;
          cmd.kind           = csvt_pkg::KIND_FIELD;
          field_nonempty_nxt = 1'b0;
          row_nonempty_nxt   = 1'b1;
        end else if (b == csvt_pkg::CH_LF) begin
          // a held carriage return before the newline is dropped
          cr_held_nxt        = 1'b0;
          cmd.has_main       = 1'b1;
          cmd.kind           = csvt_pkg::KIND_ROW;
          field_nonempty_nxt = 1'b0;
          row_nonempty_nxt   = 1'b0;
        end else begin
          do_add = 1'b1;
        end
      end

      if (do_add) begin
        cmd.has_cr  = cr_held_r;
        cr_held_nxt = (add_b == csvt_pkg::CH_CR);
        if (add_b != csvt_pkg::CH_CR) begin
          cmd.has_main = 1'b1;
          cmd.kind     = csvt_pkg::KIND_BYTE;
          cmd.content  = add_b;
        end
        field_nonempty_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_quotes_r      <= 1'b0;
      quote_pending_r  <= 1'b0;
      cr_held_r        <= 1'b0;
      field_nonempty_r <= 1'b0;
      row_nonempty_r   <= 1'b0;
    end else if (accept) begin
      in_quotes_r      <= in_quotes_nxt;
      quote_pending_r  <= quote_pending_nxt;
      cr_held_r        <= cr_held_nxt;
      field_nonempty_r <= field_nonempty_nxt;
      row_nonempty_r   <= row_nonempty_nxt;
    end
  end

  // a pending quote only exists inside quoted mode
  a_pending_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    quote_pending_r |-> in_quotes_r)
    else $error("pending quote outside quoted mode");

  // a held carriage return always belongs to a non-empty field
  a_cr_field: assert property (@(posedge clk) disable iff (!rst_n)
    cr_held_r |-> field_nonempty_r)
    else $error("held carriage return in an empty field");

  // end of input leaves the tokenizer in its start state
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.mode |=> !in_quotes_r && !cr_held_r && !field_nonempty_r
                             && !row_nonempty_r)
    else $error("state not cleared after end of input");

endmodule

FILE: rtl/csvt_queue.sv
// csvt_queue: short register queue of decoded items between front and back
// depends on csvt_pkg

module csvt_queue #(
  parameter int unsigned DEPTH = csvt_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  csvt_pkg::cmd_t  push_cmd,
  output logic            ready,
  input  logic            pop,
  output logic            nonempty,
  output csvt_pkg::cmd_t  head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  csvt_pkg::cmd_t slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign ready    = (count_r != CW'(DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> ready)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

FILE: rtl/csvt_back.sv
// csvt_back: turns queued items into one or two result transactions
// depends on csvt_pkg and csvt_if; drains csvt_queue

module csvt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_nonempty,
  input  csvt_pkg::cmd_t  q_head,
  output logic            q_pop,
  csvt_out_if.source      out_ch
);

  logic            out_valid_r;
  csvt_pkg::kind_t out_kind_r, out_kind_nxt;
  logic [7:0]      out_content_r, out_content_nxt;
  logic            out_last_r, out_last_nxt;
  logic            phase_r, phase_nxt;
  logic            load;

  assign load = q_nonempty && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_kind_nxt    = q_head.kind;
    out_content_nxt = q_head.content;
    out_last_nxt    = 1'b1;
    phase_nxt       = phase_r;
    q_pop           = 1'b0;
    if (load) begin
      if (q_head.has_cr && !phase_r) begin
        // released carriage return goes out ahead of the main result
        out_kind_nxt    = csvt_pkg::KIND_BYTE;
        out_content_nxt = csvt_pkg::CH_CR;
        out_last_nxt    = !q_head.has_main;
        phase_nxt       = q_head.has_main;
        q_pop           = !q_head.has_main;
      end else begin
        phase_nxt = 1'b0;
        q_pop     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r    <= out_kind_nxt;
      out_content_r <= out_content_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.kind    = out_kind_r;
  assign out_ch.content = out_content_r;
  assign out_ch.last    = out_last_r;

  // marks carry no content and always close their item
  a_mark_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r != csvt_pkg::KIND_BYTE |-> out_last_r && out_content_r == 8'h00)
    else $error("mark with content or not last");

  // only a released carriage return can open a two-result item
  a_first_is_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> out_kind_r == csvt_pkg::KIND_BYTE
                                   && out_content_r == csvt_pkg::CH_CR)
    else $error("first of two results is not a carriage return");

  // second half of an item is pending only while that item is at the head
  a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> q_nonempty && q_head.has_cr && q_head.has_main)
    else $error("second-half phase without a matching queued item");

endmodule

FILE: rtl/csv_byte_tokenizer.sv
// csv_byte_tokenizer: streaming csv tokenizer, top level
// depends on csvt_pkg, csvt_if, csvt_front, csvt_queue and csvt_back
//
// usage:
//   in_ch carries one transaction per input byte (mode 0) or end of input (mode 1).
//   out_ch carries result transactions: a content byte, a field end or a row end,
//   with last set on the final result of each input transaction. Inputs that
//   produce nothing (opening quote, held carriage return, ...) give no result.
//   timing: an accepted byte's result goes into the queue, then into the output register once
//   that register is free. The front accepts one byte per cycle while the queue has
//   room; the back emits one result per cycle while out_ch.ready is high, so an input
//   with a released carriage return and a second result gives two output transactions.
//   A two-entry queue between front and back absorbs that.
//   stalls: with out_ch.ready low the output register holds and the queue fills;
//   in_ch.ready drops only when the queue is full.
//   reset (rst_n low, synchronous): quote, carriage return and field/row state
//   clear, the queue empties and out_ch.valid goes low.

module csv_byte_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = csvt_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  csvt_in_if.sink     in_ch,
  csvt_out_if.source  out_ch
);

  logic           q_ready;
  logic           q_push;
  logic           q_pop;
  logic           q_nonempty;
  csvt_pkg::cmd_t front_cmd;
  csvt_pkg::cmd_t q_head;

  csvt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .push    (q_push),
    .cmd     (front_cmd)
  );

  csvt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  csvt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_ch     (out_ch)
  );

endmodule

FILE: bench/csvt_token_checker.sv
`timescale 1ns / 100ps
// csvt_token_checker: watches both channels of the csv byte tokenizer, predicts the result
// tokens of every accepted input transaction and compares them in order
// depends on csvt_pkg for the result kind codes and the special characters

module csvt_token_checker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             in_mode,
  input  logic [7:0]       in_data,
  input  logic             out_valid,
  input  logic             out_ready,
  input  csvt_pkg::kind_t  out_kind,
  input  logic [7:0]       out_content,
  input  logic             out_last,
  output int               mismatches,
  output int               pending,
  output int               results_seen,
  output int               rows_seen
);

  typedef struct packed {
    csvt_pkg::kind_t kind;
    logic [7:0]      content;
    logic            last;
  } tok_t;

  tok_t tok_expected[$];
  tok_t step_toks[$];

  // tokenizer state
  logic quoted;
  logic quote_seen;
  logic cr_hold;
  logic field_has_data;
  logic row_has_field;

  int err_cnt;
  int res_cnt;
  int row_cnt;

  function automatic void clear_state();
    quoted         = 1'b0;
    quote_seen     = 1'b0;
    cr_hold        = 1'b0;
    field_has_data = 1'b0;
    row_has_field  = 1'b0;
  endfunction

  function automatic void push_tok(csvt_pkg::kind_t k, logic [7:0] c);
    tok_t t;
    t.kind    = k;
    t.content = (k == csvt_pkg::KIND_BYTE) ? c : 8'h00;
    t.last    = 1'b0;
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void append_content(logic [7:0] b);
    if (cr_hold) begin
      push_tok(csvt_pkg::KIND_BYTE, csvt_pkg::CH_CR);
      cr_hold = 1'b0;
    end
    if (b == csvt_pkg::CH_CR) begin
      cr_hold = 1'b1;
    end else begin
      push_tok(csvt_pkg::KIND_BYTE, b);
    end
    field_has_data = 1'b1;
  endfunction

  function automatic void unquoted_byte(logic [7:0] b);
    if (b == csvt_pkg::CH_QUOTE) begin
      quoted = 1'b1;
    end else if (b == csvt_pkg::CH_COMMA) begin
      if (cr_hold) begin
        push_tok(csvt_pkg::KIND_BYTE, csvt_pkg::CH_CR);
        cr_hold = 1'b0;
      end
      push_tok(csvt_pkg::KIND_FIELD, 8'h00);
      field_has_data = 1'b0;
      row_has_field  = 1'b1;
    end else if (b == csvt_pkg::CH_LF) begin
      // a held cr right before the newline is dropped
      cr_hold = 1'b0;
      push_tok(csvt_pkg::KIND_ROW, 8'h00);
      field_has_data = 1'b0;
      row_has_field  = 1'b0;
    end else begin
      append_content(b);
    end
  endfunction

  function automatic void tokenize_byte(logic m, logic [7:0] b);
    step_toks.delete();
    if (m) begin
      if (field_has_data || row_has_field) push_tok(csvt_pkg::KIND_ROW, 8'h00);
      clear_state();
    end else if (quoted) begin
      if (quote_seen) begin
        quote_seen = 1'b0;
        if (b == csvt_pkg::CH_QUOTE) begin
          append_content(csvt_pkg::CH_QUOTE);
        end else begin
          quoted = 1'b0;
          unquoted_byte(b);
        end
      end else if (b == csvt_pkg::CH_QUOTE) begin
        quote_seen = 1'b1;
      end else begin
        append_content(b);
      end
    end else begin
      quote_seen = 1'b0;
      unquoted_byte(b);
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tok_expected.insert(tok_expected.size(), step_toks[i]);
  endfunction

  initial begin
    clear_state();
    err_cnt = 0;
    res_cnt = 0;
    row_cnt = 0;
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
    rows_seen    = 0;
  end

  always @(posedge clk) begin
    tok_t got;
    tok_t want;
    if (!rst_n) begin
      clear_state();
      tok_expected.delete();
    end else begin
      if (in_valid && in_ready) tokenize_byte(in_mode, in_data);
      if (out_valid && out_ready) begin
        got.kind    = out_kind;
        got.content = out_content;
        got.last    = out_last;
        res_cnt++;
        if (got.kind == csvt_pkg::KIND_ROW) row_cnt++;
        if (tok_expected.size() == 0) begin
          if (err_cnt < 10)
            $display("%0t: result with nothing expected: kind=%0d content=%02h last=%0b",
                     $realtime, got.kind, got.content, got.last);
          err_cnt++;
        end else begin
          want = tok_expected.pop_front();
          if (got.kind !== want.kind || got.content !== want.content ||
              got.last !== want.last) begin
            if (err_cnt < 10)
              $display("%0t: expected kind/content/last %0d/%02h/%0b, got %0d/%02h/%0b",
                       $realtime, want.kind, want.content, want.last,
                       got.kind, got.content, got.last);
            err_cnt++;
          end
        end
      end
    end
    mismatches   <= err_cnt;
    pending      <= tok_expected.size();
    results_seen <= res_cnt;
    rows_seen    <= row_cnt;
  end

endmodule

FILE: bench/tb_csv_byte_tokenizer.sv
`timescale 1ns / 100ps
// tb_csv_byte_tokenizer: stimulus and verdict for the csv byte tokenizer
// depends on csvt_pkg, csvt_if, the block itself and csvt_token_checker

module tb_csv_byte_tokenizer;

  localparam int N_ITEMS     = 1275;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 16;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();

  int mismatches;
  int pending;
  int results_seen;
  int rows_seen;

  int items_sent = 0;
  int eof_sent   = 0;
  int burst_left = 0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  always #2 clk = ~clk;

  csv_byte_tokenizer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  csvt_token_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_mode      (in_ch.mode),
    .in_data      (in_ch.data_byte),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_kind     (out_ch.kind),
    .out_content  (out_ch.content),
    .out_last     (out_ch.last),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .rows_seen    (rows_seen)
  );

  // one input transaction; bursts of random length separated by random gaps
  task automatic send_item(input logic m, input logic [7:0] b);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                               : $urandom_range(1, 24);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    items_sent++;
    if (m) eof_sent++;
  endtask

  // any byte that is not a quote, comma or newline; cr now and then
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    if ($urandom_range(0, 9) == 0) return csvt_pkg::CH_CR;
    do c = 8'($urandom_range(0, 255));
    while (c == csvt_pkg::CH_QUOTE || c == csvt_pkg::CH_COMMA || c == csvt_pkg::CH_LF);
    return c;
  endfunction

  task automatic send_row();
    int n_fields;
    int len;
    int pick;
    n_fields = $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) send_item(1'b0, csvt_pkg::CH_COMMA);
      len = $urandom_range(0, 5);
      if ($urandom_range(0, 2) == 0) begin
        send_item(1'b0, csvt_pkg::CH_QUOTE);
        for (int k = 0; k < len; k++) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0: send_item(1'b0, csvt_pkg::CH_COMMA);
            1: send_item(1'b0, csvt_pkg::CH_LF);
            2: send_item(1'b0, csvt_pkg::CH_CR);
            3: begin
              send_item(1'b0, csvt_pkg::CH_QUOTE);
              send_item(1'b0, csvt_pkg::CH_QUOTE);
            end
            default: send_item(1'b0, plain_char());
          endcase
        end
        send_item(1'b0, csvt_pkg::CH_QUOTE);
      end else begin
        for (int k = 0; k < len; k++) send_item(1'b0, plain_char());
      end
    end
    pick = $urandom_range(0, 7);
    if (pick < 5) begin
      send_item(1'b0, csvt_pkg::CH_LF);
    end else if (pick < 7) begin
      send_item(1'b0, csvt_pkg::CH_CR);
      send_item(1'b0, csvt_pkg::CH_LF);
    end
  endtask

  // receiver: changes its stall pattern every phase, one long hold-off on request
  initial begin : receiver
    int style;
    int phase_len;
    int hold_cnt;
    out_ch.ready <= 1'b0;
    forever begin
      style     = $urandom_range(0, 3);
      phase_len = $urandom_range(20, 120);
      for (int i = 0; i < phase_len; i++) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          out_ch.ready <= 1'b0;
          for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
          hold_done = 1'b1;
        end
        case (style)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ((i % 4) != 3);
          default: out_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("[csv_byte_tokenizer] ERROR");
    $finish;
  end

  initial begin : stimulus
    int pick;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= 1'b0;
    in_ch.data_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: end of input on an empty stream, extremes, cr handling
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, csvt_pkg::CH_CR);
    send_item(1'b0, 8'h41);                  // held cr released before content
    send_item(1'b0, csvt_pkg::CH_CR);
    send_item(1'b0, csvt_pkg::CH_COMMA);     // held cr released before field end
    send_item(1'b0, csvt_pkg::CH_LF);
    send_item(1'b0, csvt_pkg::CH_LF);        // newline on an empty row
    // quote opening mid field, quoted comma and newline, doubled quote
    send_item(1'b0, 8'h62);
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b0, csvt_pkg::CH_COMMA);
    send_item(1'b0, csvt_pkg::CH_LF);
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b0, csvt_pkg::CH_CR);
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b0, csvt_pkg::CH_LF);        // pending quote then newline, cr dropped
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b0, 8'h71);
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b0, csvt_pkg::CH_COMMA);     // pending quote then comma
    send_item(1'b0, csvt_pkg::CH_CR);
    send_item(1'b1, 8'hFF);                  // end of input drops the held cr
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b0, 8'h7A);
    send_item(1'b1, 8'h55);                  // end of input inside quotes
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b0, 8'h80);
    send_item(1'b0, csvt_pkg::CH_QUOTE);
    send_item(1'b1, 8'hAA);                  // end of input with a pending quote

    // random: mostly well-formed rows, some end-of-input and raw noise
    while (items_sent < N_ITEMS) begin
      if (!hold_req && items_sent >= 400) hold_req = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_row();
      end else if (pick < 8) begin
        send_item(1'b1, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(($urandom_range(0, 7) == 0), 8'($urandom_range(0, 255)));
      end
    end
    send_item(1'b1, 8'($urandom_range(0, 255)));
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d input transactions (%0d end of input), long output hold-off %0s",
             items_sent, eof_sent, hold_done ? "done" : "not reached");
    $display("checked %0d result transactions, %0d row ends, %0d mismatches",
             results_seen, rows_seen, mismatches);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("[csv_byte_tokenizer] OK");
    end else begin
      $display("[csv_byte_tokenizer] ERROR");
    end
    $finish;
  end

endmodule
